// ===== rtl/text_line_cleanup_filter_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef TEXT_LINE_CLEANUP_FILTER_MACROS_SVH
`define TEXT_LINE_CLEANUP_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TLCF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TLCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tlcf_pkg.sv =====
// Package: shared types and constants of the text line cleanup filter.
package tlcf_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [7:0] LIMIT_RESET = 8'd200;

    localparam logic [7:0] CH_NL   = 8'd10;
    localparam logic [7:0] CH_SP   = 8'd32;
    localparam logic [7:0] CH_TAB  = 8'd9;
    localparam logic [7:0] CH_BSL  = 8'd92;
    localparam logic [7:0] CH_HASH = 8'd35;

    // One accepted input byte's worth of results: cnt of 1 to 3 bytes.
    typedef struct packed {
        logic            err;
        logic [1:0]      cnt;
        logic [2:0][7:0] data;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== rtl/tlcf_front.sv =====
// Front end: accepts bytes, runs the tokeniser and produces result commands.
module tlcf_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          in_byte,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  tlcf_pkg::fifo_stat_t q_stat,
    output logic                push,
    output tlcf_pkg::cmd_t      push_cmd
);

    typedef enum logic [2:0] {
        PH_GAP   = 3'd0,
        PH_TOKEN = 3'd1,
        PH_HELD  = 3'd2,
        PH_SKIP  = 3'd3,
        PH_JOIN  = 3'd4
    } phase_t;

    phase_t     phase_reg,  phase_next;
    logic       kind_reg,   kind_next;
    logic       ended_reg,  ended_next;
    logic       tsl_reg,    tsl_next;
    logic       lho_reg,    lho_next;
    logic [7:0] len_reg,    len_next;
    logic       halted_reg, halted_next;
    logic [7:0] limit_reg,  limit_next;

    logic            accept;
    logic            nl;
    logic            ws;
    logic            over;
    logic            do_start;
    logic            do_end;
    logic            do_join;
    logic [7:0]      hc;
    logic [1:0]      n;
    logic [2:0][7:0] b;
    logic            err;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign nl       = (in_byte == tlcf_pkg::CH_NL);
    assign ws       = (in_byte == tlcf_pkg::CH_SP) || (in_byte == tlcf_pkg::CH_TAB);
    assign hc       = kind_reg ? tlcf_pkg::CH_HASH : tlcf_pkg::CH_BSL;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        ended_next  = ended_reg;
        tsl_next    = tsl_reg;
        lho_next    = lho_reg;
        len_next    = len_reg;
        halted_next = halted_reg;
        limit_next  = cfg_we ? cfg_wdata : limit_reg;
        do_start    = 1'b0;
        do_end      = 1'b0;
        do_join     = 1'b0;
        n           = 2'd0;
        b           = '0;
        err         = 1'b0;
        over        = nl ? (len_reg >= limit_reg)
                         : (({1'b0, len_reg} + 9'd1) >= {1'b0, limit_reg});

        if (accept && !halted_reg)
        begin
            if (over)
            begin
                halted_next = 1'b1;
                err         = 1'b1;
                n           = 2'd1;
            end
            else
            begin
                len_next = nl ? 8'd0 : len_reg + 8'd1;
                unique case (phase_reg)
                    PH_TOKEN:
                    begin
                        if (nl)
                            do_end = 1'b1;
                        else if (ws)
                            phase_next = PH_GAP;
                        else
                        begin
                            b[n] = in_byte;
                            n    = n + 2'd1;
                        end
                    end
                    PH_HELD:
                    begin
                        if (!ended_reg)
                        begin
                            if (nl)
                            begin
                                if (kind_reg)
                                    do_end = 1'b1;
                                else
                                    do_join = 1'b1;
                            end
                            else if (ws)
                            begin
                                if (kind_reg)
                                begin
                                    phase_next = PH_SKIP;
                                    kind_next  = 1'b0;
                                    ended_next = 1'b0;
                                end
                                else
                                    ended_next = 1'b1;
                            end
                            else
                            begin
                                b[n]       = hc;
                                n          = n + 2'd1;
                                b[n]       = in_byte;
                                n          = n + 2'd1;
                                lho_next   = 1'b1;
                                phase_next = PH_TOKEN;
                                kind_next  = 1'b0;
                                ended_next = 1'b0;
                            end
                        end
                        else
                        begin
                            if (nl)
                                do_join = 1'b1;
                            else if (!ws)
                            begin
                                b[n]       = hc;
                                n          = n + 2'd1;
                                lho_next   = 1'b1;
                                phase_next = PH_GAP;
                                kind_next  = 1'b0;
                                ended_next = 1'b0;
                                do_start   = 1'b1;
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        if (nl)
                            do_end = 1'b1;
                    end
                    PH_JOIN:
                    begin
                        if (!nl && !ws)
                            do_start = 1'b1;
                    end
                    default:
                    begin
                        if (nl)
                            do_end = 1'b1;
                        else if (!ws)
                            do_start = 1'b1;
                        else
                            phase_next = PH_GAP;
                    end
                endcase

                if (do_end)
                begin
                    if (lho_next)
                    begin
                        b[n] = tlcf_pkg::CH_NL;
                        n    = n + 2'd1;
                    end
                    lho_next   = 1'b0;
                    tsl_next   = 1'b0;
                    phase_next = PH_GAP;
                    kind_next  = 1'b0;
                    ended_next = 1'b0;
                end

                if (do_join)
                begin
                    tsl_next   = 1'b0;
                    phase_next = PH_JOIN;
                    kind_next  = 1'b0;
                    ended_next = 1'b0;
                end

                if (do_start)
                begin
                    if (tsl_next)
                    begin
                        b[n] = tlcf_pkg::CH_SP;
                        n    = n + 2'd1;
                    end
                    tsl_next = 1'b1;
                    if (in_byte == tlcf_pkg::CH_BSL || in_byte == tlcf_pkg::CH_HASH)
                    begin
                        phase_next = PH_HELD;
                        kind_next  = (in_byte == tlcf_pkg::CH_HASH);
                        ended_next = 1'b0;
                    end
                    else
                    begin
                        b[n]       = in_byte;
                        n          = n + 2'd1;
                        lho_next   = 1'b1;
                        phase_next = PH_TOKEN;
                    end
                end
            end
        end
    end

    assign push          = (n != 2'd0);
    assign push_cmd.err  = err;
    assign push_cmd.cnt  = n;
    assign push_cmd.data = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_GAP;
            kind_reg   <= 1'b0;
            ended_reg  <= 1'b0;
            tsl_reg    <= 1'b0;
            lho_reg    <= 1'b0;
            len_reg    <= 8'd0;
            halted_reg <= 1'b0;
            limit_reg  <= tlcf_pkg::LIMIT_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            ended_reg  <= ended_next;
            tsl_reg    <= tsl_next;
            lho_reg    <= lho_next;
            len_reg    <= len_next;
            halted_reg <= halted_next;
            limit_reg  <= limit_next;
        end
    end

endmodule

// ===== rtl/tlcf_fifo.sv =====
// Command queue between the front end and the output sequencer.
module tlcf_fifo
#(
    parameter int unsigned DEPTH = tlcf_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlcf_pkg::cmd_t       wr_data,
    input  logic                 pop,
    output tlcf_pkg::cmd_t       rd_data,
    output tlcf_pkg::fifo_stat_t stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    tlcf_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg,  count_next;
    logic           do_wr;
    logic           do_rd;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = push && !stat.full;
    assign do_rd      = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/tlcf_back.sv =====
// Back end: unpacks queued commands into single output items.
module tlcf_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlcf_pkg::cmd_t       q_data,
    input  tlcf_pkg::fifo_stat_t q_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 error,
    output logic                 last
);

    tlcf_pkg::cmd_t cmd_reg,   cmd_next;
    logic           valid_reg, valid_next;
    logic [1:0]     idx_reg,   idx_next;
    logic           is_last;
    logic           done;

    assign is_last   = (idx_reg == (cmd_reg.cnt - 2'd1));
    assign done      = valid_reg && !out_stall && is_last;
    assign pop       = !q_stat.empty && (!valid_reg || done);

    assign out_valid = valid_reg;
    assign out_byte  = cmd_reg.data[idx_reg];
    assign error     = cmd_reg.err;
    assign last      = is_last;

    always_comb
    begin
        cmd_next   = cmd_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            cmd_next   = q_data;
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (done)
            valid_next = 1'b0;
        else if (valid_reg && !out_stall)
            idx_next = idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ===== rtl/text_line_cleanup_filter.sv =====
// Results of accepted bytes wait in the command queue (QUEUE_DEPTH entries),
// which absorbs the bursts, and leave through the back end one item at a time.
// Input: one byte per cycle while in_stall is low (a full queue stalls it).
// Reset: asynchronous, active low; clears tokeniser state, queue and output,
// line limit returns to 200.
module text_line_cleanup_filter
#(
    parameter int unsigned QUEUE_DEPTH = tlcf_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       error,
    output logic       last
);

    tlcf_pkg::fifo_stat_t q_stat;
    tlcf_pkg::cmd_t       push_cmd;
    tlcf_pkg::cmd_t       q_data;
    logic                 push;
    logic                 pop;

    tlcf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tlcf_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .pop     (pop),
        .rd_data (q_data),
        .stat    (q_stat)
    );

    tlcf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .error     (error),
        .last      (last)
    );

endmodule

// ===== rtl/tlcf_checker.sv =====
// Port-level checker for the text line cleanup filter, with its bind.
`include "text_line_cleanup_filter_macros.svh"

module tlcf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       error,
    input logic       last
);

    `TLCF_ASSERT_SAME(a_err_last, out_valid && error, last, "error item not marked last")
    `TLCF_ASSERT_SAME(a_err_zero, out_valid && error, out_byte == 8'd0, "error item byte not zero")
    `TLCF_ASSERT_NEXT(a_halt_quiet, out_valid && error && !out_stall, !out_valid, "item after error")
    `TLCF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte), "stalled item changed")

endmodule

bind text_line_cleanup_filter tlcf_checker u_tlcf_checker (.*);

// ===== tb/text_line_cleanup_filter_checker.sv =====
// Checker for the text line cleanup filter: predicts each item's output bytes and compares.
`timescale 1ns / 1ps

module text_line_cleanup_filter_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       error,
    input  logic       last,
    input  logic       end_check,
    output int         fail_count,
    output int         pending,
    output int         results_seen,
    output int         errors_seen
);

    typedef enum logic [2:0] {
        BETWEEN  = 3'd0,
        IN_WORD  = 3'd1,
        HOLDING  = 3'd2,
        DROPPING = 3'd3,
        JOINED   = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       err;
        logic       fin;
    } result_t;

    result_t    expected_bytes[$];
    result_t    step_res[3];
    int         step_n;

    logic [7:0] limit;
    mode_t      mode;
    logic       hold_hash;
    logic       hold_closed;
    logic       word_on_line;
    logic       line_has_text;
    logic [7:0] line_len;
    logic       halted;

    int         fails;
    int         results;
    int         errs;
    logic       leftover_checked;
    result_t    got;
    result_t    want;

    function automatic void put_char(logic [7:0] b);
        step_res[step_n] = '{ch: b, err: 1'b0, fin: 1'b0};
        step_n = step_n + 1;
    endfunction

    function automatic void drop_hold();
        hold_hash   = 1'b0;
        hold_closed = 1'b0;
    endfunction

    function automatic void close_line();
        if (line_has_text)
            put_char(tlcf_pkg::CH_NL);
        line_has_text = 1'b0;
        word_on_line  = 1'b0;
        mode          = BETWEEN;
        drop_hold();
    endfunction

    function automatic void join_next();
        word_on_line = 1'b0;
        mode         = JOINED;
        drop_hold();
    endfunction

    function automatic void open_word(logic [7:0] c);
        if (word_on_line)
            put_char(tlcf_pkg::CH_SP);
        word_on_line = 1'b1;
        if (c == tlcf_pkg::CH_BSL || c == tlcf_pkg::CH_HASH)
        begin
            mode        = HOLDING;
            hold_hash   = (c == tlcf_pkg::CH_HASH);
            hold_closed = 1'b0;
        end
        else
        begin
            put_char(c);
            line_has_text = 1'b1;
            mode          = IN_WORD;
        end
    endfunction

    // Works out the output bytes one input byte causes and queues them.
    function automatic void filter_byte(logic [7:0] c);
        logic       nl;
        logic       ws;
        logic       over;
        logic [7:0] hc;
        nl     = (c == tlcf_pkg::CH_NL);
        ws     = (c == tlcf_pkg::CH_SP) || (c == tlcf_pkg::CH_TAB);
        step_n = 0;
        if (halted)
            return;
        if (nl)
            over = int'(line_len) >= int'(limit);
        else
            over = int'(line_len) + 1 >= int'(limit);
        if (over)
        begin
            halted = 1'b1;
            expected_bytes.push_back('{ch: 8'd0, err: 1'b1, fin: 1'b1});
            return;
        end
        line_len = nl ? 8'd0 : line_len + 8'd1;

        case (mode)
            IN_WORD:
            begin
                if (nl)
                    close_line();
                else if (ws)
                    mode = BETWEEN;
                else
                    put_char(c);
            end
            HOLDING:
            begin
                hc = hold_hash ? tlcf_pkg::CH_HASH : tlcf_pkg::CH_BSL;
                if (!hold_closed)
                begin
                    if (nl)
                    begin
                        if (hold_hash)
                            close_line();
                        else
                            join_next();
                    end
                    else if (ws)
                    begin
                        if (hold_hash)
                        begin
                            mode = DROPPING;
                            drop_hold();
                        end
                        else
                            hold_closed = 1'b1;
                    end
                    else
                    begin
                        put_char(hc);
                        put_char(c);
                        line_has_text = 1'b1;
                        mode          = IN_WORD;
                        drop_hold();
                    end
                end
                else
                begin
                    if (nl)
                        join_next();
                    else if (!ws)
                    begin
                        put_char(hc);
                        line_has_text = 1'b1;
                        mode          = BETWEEN;
                        drop_hold();
                        open_word(c);
                    end
                end
            end
            DROPPING:
            begin
                if (nl)
                    close_line();
            end
            JOINED:
            begin
                if (!nl && !ws)
                    open_word(c);
            end
            default:
            begin
                if (nl)
                    close_line();
                else if (!ws)
                    open_word(c);
                else
                    mode = BETWEEN;
            end
        endcase

        if (step_n > 0)
            step_res[step_n - 1].fin = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_bytes.push_back(step_res[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_bytes.delete();
            limit            = tlcf_pkg::LIMIT_RESET;
            mode             = BETWEEN;
            hold_hash        = 1'b0;
            hold_closed      = 1'b0;
            word_on_line     = 1'b0;
            line_has_text    = 1'b0;
            line_len         = 8'd0;
            halted           = 1'b0;
            fails            = 0;
            results          = 0;
            errs             = 0;
            leftover_checked = 1'b0;
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
            errors_seen  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{ch: out_byte, err: error, fin: last};
                results++;
                if (error === 1'b1)
                    errs++;
                if (expected_bytes.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected item: byte %02h error %b last %b",
                                 $realtime, out_byte, error, last);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch: want %02h/%b/%b, got %02h/%b/%b",
                                     $realtime, want.ch, want.err, want.fin,
                                     got.ch, got.err, got.fin);
                    end
                end
            end
            if (cfg_we)
                limit = cfg_wdata;
            if (in_valid && !in_stall)
                filter_byte(in_byte);
            if (end_check && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (expected_bytes.size() != 0)
                begin
                    fails += expected_bytes.size();
                    $display("%0d expected items never arrived", expected_bytes.size());
                end
            end
            fail_count   <= fails;
            pending      <= expected_bytes.size();
            results_seen <= results;
            errors_seen  <= errs;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives text streams and line limits into the filter and reports the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_CYCLES = 2000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'd0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       error;
    logic       last;
    logic       end_check = 1'b0;

    int         fail_count;
    int         pending;
    int         results_seen;
    int         errors_seen;

    int         items_sent  = 0;
    int         line_used   = 0;
    int         cur_limit   = 200;
    int         settings    = 0;
    int         idle_cycles = 0;
    bit         calm        = 1'b0;
    bit         overflow_ok = 1'b0;

    text_line_cleanup_filter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .error     (error),
        .last      (last)
    );

    text_line_cleanup_filter_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .error        (error),
        .last         (last),
        .end_check    (end_check),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .errors_seen  (errors_seen)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 27);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == tlcf_pkg::CH_NL || c == tlcf_pkg::CH_SP || c == tlcf_pkg::CH_TAB);
        return c;
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(0, 1) ? tlcf_pkg::CH_SP : tlcf_pkg::CH_TAB;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        line_used = (b == tlcf_pkg::CH_NL) ? 0 : line_used + 1;
    endtask

    // Breaks the line early so that the limit is only reached on purpose.
    task automatic put_byte(input logic [7:0] b);
        if (b != tlcf_pkg::CH_NL && !overflow_ok && line_used + 1 >= cur_limit)
            send_byte(tlcf_pkg::CH_NL);
        send_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        if (line_used != 0)
            put_byte(tlcf_pkg::CH_NL);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_limit = int'(v);
        settings++;
    endtask

    task automatic put_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            repeat ($urandom_range(1, 3)) put_byte(blank());
        else if (r < 85)
            put_byte(tlcf_pkg::CH_NL);
    endtask

    // Mostly well-formed token streams, with some raw noise.
    task automatic random_stream(input int count, input int word_max);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                repeat ($urandom_range(1, word_max)) put_byte(word_char());
                put_gap();
            end
            else if (pick < 55)
            begin
                put_byte(tlcf_pkg::CH_HASH);
                if ($urandom_range(0, 1))
                begin
                    put_byte(blank());
                    repeat ($urandom_range(0, 6))
                        put_byte(($urandom_range(0, 3) == 0) ? blank() : word_char());
                end
                put_byte(tlcf_pkg::CH_NL);
            end
            else if (pick < 65)
            begin
                put_byte(tlcf_pkg::CH_BSL);
                repeat ($urandom_range(0, 2)) put_byte(blank());
                put_byte(tlcf_pkg::CH_NL);
                repeat ($urandom_range(0, 2))
                begin
                    repeat ($urandom_range(0, 2)) put_byte(blank());
                    put_byte(tlcf_pkg::CH_NL);
                end
            end
            else if (pick < 73)
            begin
                put_byte($urandom_range(0, 1) ? tlcf_pkg::CH_HASH : tlcf_pkg::CH_BSL);
                repeat ($urandom_range(1, 4)) put_byte(word_char());
                put_gap();
            end
            else if (pick < 81)
            begin
                put_byte($urandom_range(0, 3) == 0 ? tlcf_pkg::CH_HASH : tlcf_pkg::CH_BSL);
                put_byte(blank());
            end
            else if (pick < 90)
                put_byte(tlcf_pkg::CH_NL);
            else
            begin
                repeat ($urandom_range(1, 5))
                begin
                    case ($urandom_range(0, 9))
                        0: put_byte(tlcf_pkg::CH_NL);
                        1: put_byte(tlcf_pkg::CH_BSL);
                        2: put_byte(tlcf_pkg::CH_HASH);
                        3: put_byte(blank());
                        default: put_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_limit(tlcf_pkg::LIMIT_RESET);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(tlcf_pkg::CH_NL);
        send_text("q\t#\n");
        send_text("#1 \\\t\n\nw\n");
        send_text("\\k \\ v\n");
        send_text("# z\n");
        random_stream(100, 6);

        set_limit(8'd255);
        random_stream(80, 40);

        set_limit(8'($urandom_range(20, 60)));
        calm = 1'b1;
        random_stream(80, 8);
        calm = 1'b0;

        // at limit 1 only empty lines get through
        set_limit(8'd1);
        repeat (6) send_byte(tlcf_pkg::CH_NL);

        set_limit(8'($urandom_range(2, 10)));
        random_stream(60, 4);

        set_limit(8'd200);
        random_stream(30, 6);
        drain();
        random_stream(30, 6);

        // last setting: run a line past the limit, then the block stays halted
        overflow_ok = 1'b1;
        set_limit(8'($urandom_range(8, 30)));
        repeat (cur_limit + 6)
            put_byte(($urandom_range(0, 3) == 0) ? blank() : word_char());
        repeat (3) put_byte(tlcf_pkg::CH_NL);

        drain();
        end_check <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Covered %0d input bytes over %0d line limit settings,",
                 items_sent, settings);
        $display("%0d output items, %0d of them overflow errors", results_seen, errors_seen);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tlcf_pkg.sv
rtl/tlcf_front.sv
rtl/tlcf_fifo.sv
rtl/tlcf_back.sv
rtl/text_line_cleanup_filter.sv
rtl/tlcf_checker.sv
tb/text_line_cleanup_filter_checker.sv
tb/testbench.sv
